// ----- hw/rtl/ftws_pkg.sv -----
package ftws_pkg;

   // history ring geometry
   localparam int HISTORY_DEPTH = 64;
   localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
   localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

   // field widths
   localparam int TICK_W  = 32;
   localparam int STAMP_W = 64;
   localparam int WIN_W   = 7;
   localparam int SUM_W   = TICK_W + ADDR_W + 1;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic REG_MONITOR_ENABLE = 1'b0;
   localparam logic REG_WINDOW_SIZE    = 1'b1;

   // command codes
   localparam logic [1:0] OP_FRAME_START = 2'd0;
   localparam logic [1:0] OP_FRAME_END   = 2'd1;
   localparam logic [1:0] OP_CLEAR       = 2'd2;

   // scan sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_LAST,
      ST_DIV_START,
      ST_DIV,
      ST_DONE
   } state_type;

   // divider status back to the sequencer
   typedef struct packed {
      logic              done;
      logic [TICK_W-1:0] quotient;
   } div_stat_type;

endpackage

// ----- hw/rtl/ftws_hist_ram.sv -----
module ftws_hist_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ftws_divider.sv -----
module ftws_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ftws_pkg::SUM_W-1:0]    dividend,
   input  logic [ftws_pkg::CNT_W-1:0]    divisor,
   output ftws_pkg::div_stat_type        stat
);
   import ftws_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  div_ff, div_in;
   logic [CNT_W:0]    trial;
   logic              fits;

   // one restoring step: shift in next dividend bit, subtract if it fits
   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      fits  = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         rem_in  = fits ? CNT_W'(trial - {1'b0, div_ff}) : CNT_W'(trial);
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = quo_ff[TICK_W-1:0];

endmodule

// ----- hw/rtl/frame_time_window_stats.sv -----
// Frame-time monitor over a sliding window of recent frames.
// Input channel req_*: one command transaction per accept, opcode plus a
// 64-bit timestamp. Frame start latches the stamp, clear empties the window
// and zeroes the frame count; neither gives a result.
// Frame end computes the saturated elapsed ticks, stores them in a
// 64-entry history memory and gives one rsp_* transaction with the frame
// time, window minimum, maximum, truncated mean, frame count and fill count.
// The result passes through one memory read per stored entry, then a
// bit-serial divider that resolves one quotient bit per cycle over 39
// bits, before it is loaded into the output register; the next command is
// taken once that result has been loaded.
// req_ready is high only while no frame end is in work.
// The result sits in an output register, so start and clear commands and a
// following frame end keep flowing while rsp_ready is low; a second result
// waits inside the block until the first one is taken.
// csr_*: APB-style port, monitor_enable at 0x0, window_size at 0x4; writing
// window_size empties the window. Synchronous reset restores register
// defaults (enabled, window 64) and empties the window; it takes effect at
// once, with no clearing pass over the memory.
module frame_time_window_stats (
   input  logic                          clock,
   input  logic                          reset,
   // command channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_opcode,
   input  logic [ftws_pkg::STAMP_W-1:0]  req_timestamp,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ftws_pkg::TICK_W-1:0]   rsp_frame_ticks,
   output logic [ftws_pkg::TICK_W-1:0]   rsp_average_ticks,
   output logic [ftws_pkg::TICK_W-1:0]   rsp_minimum_ticks,
   output logic [ftws_pkg::TICK_W-1:0]   rsp_maximum_ticks,
   output logic [ftws_pkg::TICK_W-1:0]   rsp_frames_ended,
   output logic [ftws_pkg::WIN_W-1:0]    rsp_window_filled,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ftws_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [ftws_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ftws_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import ftws_pkg::*;

   state_type state_ff, state_in;

   logic                enable_ff, enable_in;
   logic [WIN_W-1:0]    wsize_ff, wsize_in;
   logic [STAMP_W-1:0]  stamp_ff, stamp_in;
   logic [ADDR_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]    filled_ff, filled_in;
   logic [TICK_W-1:0]   tally_ff, tally_in;

   logic [TICK_W-1:0]   ticks_ff, ticks_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic                pend_ff;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [TICK_W-1:0]   min_ff, min_in;
   logic [TICK_W-1:0]   max_ff, max_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [TICK_W-1:0]   rsp_ticks_ff, rsp_avg_ff, rsp_min_ff, rsp_max_ff, rsp_tally_ff;
   logic [CNT_W-1:0]    rsp_filled_ff;

   logic                csr_wr;
   logic                accept;
   logic                cmd_start, cmd_end, cmd_clear;
   logic [CNT_W-1:0]    win_eff;
   logic [ADDR_W-1:0]   slot_use;
   logic [CNT_W-1:0]    slot_next;
   logic [CNT_W-1:0]    filled_clamp;
   logic [STAMP_W-1:0]  elapsed;
   logic [TICK_W-1:0]   ticks_new;
   logic                last_read;

   logic                mem_wr;
   logic                mem_rd;
   logic [TICK_W-1:0]   mem_rdata;
   logic                div_start;
   logic                load_rsp;
   div_stat_type        div_stat;

   // configuration access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[2])
         REG_MONITOR_ENABLE: csr_prdata = CSR_DW'(enable_ff);
         REG_WINDOW_SIZE:    csr_prdata = CSR_DW'(wsize_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // command decode
   assign accept    = req_valid && req_ready;
   assign cmd_start = accept && enable_ff && (req_opcode == OP_FRAME_START);
   assign cmd_end   = accept && enable_ff && (req_opcode == OP_FRAME_END);
   assign cmd_clear = accept && enable_ff && (req_opcode == OP_CLEAR);

   // effective window and ring pointer update for a frame end
   always_comb begin
      if (wsize_ff == '0) begin
         win_eff = CNT_W'(1);
      end else if (int'(wsize_ff) > HISTORY_DEPTH) begin
         win_eff = CNT_W'(HISTORY_DEPTH);
      end else begin
         win_eff = CNT_W'(wsize_ff);
      end
      slot_use     = (CNT_W'(slot_ff) >= win_eff) ? '0 : slot_ff;
      slot_next    = CNT_W'(slot_use) + 1'b1;
      filled_clamp = (filled_ff > win_eff) ? win_eff : filled_ff;
      elapsed      = req_timestamp - stamp_ff;
      ticks_new    = (elapsed[STAMP_W-1:TICK_W] != '0) ? '1 : elapsed[TICK_W-1:0];
   end

   assign last_read = (CNT_W'(idx_ff) == (filled_ff - 1'b1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (cmd_end) state_in = ST_READ;
         ST_READ:      if (last_read) state_in = ST_LAST;
         ST_LAST:      state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV;
         ST_DIV:       if (div_stat.done) state_in = ST_DONE;
         ST_DONE:      if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE:      begin
            req_ready = 1'b1;
            mem_wr    = cmd_end;
         end
         ST_READ:      mem_rd = 1'b1;
         ST_LAST:      ;
         ST_DIV_START: div_start = 1'b1;
         ST_DIV:       ;
         ST_DONE:      load_rsp = !rsp_valid_ff || rsp_ready;
         default:      ;
      endcase
   end

   // architectural state update
   always_comb begin
      enable_in = enable_ff;
      wsize_in  = wsize_ff;
      stamp_in  = stamp_ff;
      slot_in   = slot_ff;
      filled_in = filled_ff;
      tally_in  = tally_ff;
      ticks_in  = ticks_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_MONITOR_ENABLE: enable_in = csr_pwdata[0];
            REG_WINDOW_SIZE:    begin
               wsize_in  = csr_pwdata[WIN_W-1:0];
               slot_in   = '0;
               filled_in = '0;
            end
            default:            ;
         endcase
      end
      if (cmd_start) begin
         stamp_in = req_timestamp;
      end
      if (cmd_clear) begin
         slot_in   = '0;
         filled_in = '0;
         tally_in  = '0;
      end
      if (cmd_end) begin
         ticks_in  = ticks_new;
         tally_in  = tally_ff + 1'b1;
         slot_in   = (slot_next >= win_eff) ? '0 : ADDR_W'(slot_next);
         filled_in = (filled_clamp < win_eff) ? filled_clamp + 1'b1 : filled_clamp;
      end
   end

   // scan index and running min, max and sum
   always_comb begin
      idx_in = idx_ff;
      sum_in = sum_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (cmd_end) begin
         idx_in = '0;
         sum_in = '0;
         min_in = '1;
         max_in = '0;
      end else if (mem_rd) begin
         idx_in = idx_ff + 1'b1;
      end
      if (pend_ff) begin
         sum_in = sum_ff + SUM_W'(mem_rdata);
         if (mem_rdata < min_ff) min_in = mem_rdata;
         if (mem_rdata > max_ff) max_in = mem_rdata;
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b1;
         wsize_ff     <= WIN_W'(HISTORY_DEPTH);
         stamp_ff     <= '0;
         slot_ff      <= '0;
         filled_ff    <= '0;
         tally_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         wsize_ff     <= wsize_in;
         stamp_ff     <= stamp_in;
         slot_ff      <= slot_in;
         filled_ff    <= filled_in;
         tally_ff     <= tally_in;
         pend_ff      <= mem_rd;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      ticks_ff <= ticks_in;
      idx_ff   <= idx_in;
      sum_ff   <= sum_in;
      min_ff   <= min_in;
      max_ff   <= max_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ticks_ff  <= ticks_ff;
         rsp_avg_ff    <= div_stat.quotient;
         rsp_min_ff    <= min_ff;
         rsp_max_ff    <= max_ff;
         rsp_tally_ff  <= tally_ff;
         rsp_filled_ff <= filled_ff;
      end
   end

   // history memory
   ftws_hist_ram #(
      .DATA_W (TICK_W),
      .DEPTH  (HISTORY_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (slot_use),
      .wr_data (ticks_new),
      .rd_en   (mem_rd),
      .rd_addr (idx_ff),
      .rd_data (mem_rdata)
   );

   // mean of the window
   ftws_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (filled_ff),
      .stat     (div_stat)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_ticks   = rsp_ticks_ff;
   assign rsp_average_ticks = rsp_avg_ff;
   assign rsp_minimum_ticks = rsp_min_ff;
   assign rsp_maximum_ticks = rsp_max_ff;
   assign rsp_frames_ended  = rsp_tally_ff;
   assign rsp_window_filled = WIN_W'(rsp_filled_ff);

endmodule

// ----- tb/sv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ftws_pkg::*;

   // opcode 3 has no meaning in the block and must be dropped
   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         RUN_LIMIT     = 1_000_000;
   localparam int         SETTLE_CYCLES = 120;
   localparam int         PRINT_LIMIT   = 40;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [STAMP_W-1:0] stamp;
   } command_type;

   typedef struct packed {
      logic [TICK_W-1:0] frame_ticks;
      logic [TICK_W-1:0] average_ticks;
      logic [TICK_W-1:0] minimum_ticks;
      logic [TICK_W-1:0] maximum_ticks;
      logic [TICK_W-1:0] frames_ended;
      logic [WIN_W-1:0]  window_filled;
   } frame_stats_type;

   // block ports
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_opcode = '0;
   logic [STAMP_W-1:0]  req_timestamp = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [TICK_W-1:0]   rsp_frame_ticks;
   logic [TICK_W-1:0]   rsp_average_ticks;
   logic [TICK_W-1:0]   rsp_minimum_ticks;
   logic [TICK_W-1:0]   rsp_maximum_ticks;
   logic [TICK_W-1:0]   rsp_frames_ended;
   logic [WIN_W-1:0]    rsp_window_filled;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // predictor state, mirrors the block's registers and history ring
   logic [STAMP_W-1:0]  held_start = '0;
   logic [TICK_W-1:0]   tick_ring [HISTORY_DEPTH];
   int                  ring_slot = 0;
   int                  ring_fill = 0;
   logic [TICK_W-1:0]   ends_since_clear = '0;
   logic                mon_enabled = 1'b1;
   logic [WIN_W-1:0]    win_setting = WIN_W'(HISTORY_DEPTH);

   // queues and bookkeeping
   command_type         pending_cmds [$];
   frame_stats_type     expected_stats [$];
   command_type         shown_cmd;
   logic [STAMP_W-1:0]  stamp_now = '0;
   int                  cmds_queued = 0;
   int                  cmds_accepted = 0;
   int                  results_checked = 0;
   int                  saturated_ends = 0;
   int                  register_writes = 0;
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  send_wait = 0;
   int                  recv_wait = 0;
   bit                  send_idle = 1'b0;
   bit                  recv_idle = 1'b0;

   frame_time_window_stats DUT (.*);

   // clock
   always #5 clock = ~clock;

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // random gap: mostly none, some short, a few long
   function automatic int pick_gap(bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                   results_checked, name, got, want));
   endtask

   // expected stats for one accepted command transaction
   task automatic predict_window_stats(command_type cmd);
      logic [STAMP_W-1:0] elapsed;
      logic [TICK_W-1:0]  ticks;
      logic [TICK_W-1:0]  lo;
      logic [TICK_W-1:0]  hi;
      logic [63:0]        total;
      int                 span;
      frame_stats_type    fs;
      if (!mon_enabled) return;
      case (cmd.opcode)
         OP_FRAME_START: begin
            held_start = cmd.stamp;
         end
         OP_CLEAR: begin
            ring_slot        = 0;
            ring_fill        = 0;
            ends_since_clear = '0;
         end
         OP_FRAME_END: begin
            elapsed = cmd.stamp - held_start;
            if (elapsed > 64'hFFFF_FFFF) begin
               ticks = '1;
               saturated_ends++;
            end else begin
               ticks = elapsed[TICK_W-1:0];
            end
            ends_since_clear = ends_since_clear + 1'b1;
            // window setting clamps to 1..HISTORY_DEPTH
            span = (win_setting == 0) ? 1 :
                   (win_setting > HISTORY_DEPTH) ? HISTORY_DEPTH : int'(win_setting);
            if (ring_slot >= span) ring_slot = 0;
            if (ring_fill > span) ring_fill = span;
            tick_ring[ring_slot] = ticks;
            ring_slot++;
            if (ring_slot >= span) ring_slot = 0;
            if (ring_fill < span) ring_fill++;
            total = '0;
            lo    = '1;
            hi    = '0;
            for (int i = 0; i < ring_fill; i++) begin
               total += 64'(tick_ring[i]);
               if (tick_ring[i] < lo) lo = tick_ring[i];
               if (tick_ring[i] > hi) hi = tick_ring[i];
            end
            fs.frame_ticks   = ticks;
            fs.average_ticks = TICK_W'(total / 64'(ring_fill));
            fs.minimum_ticks = lo;
            fs.maximum_ticks = hi;
            fs.frames_ended  = ends_since_clear;
            fs.window_filled = WIN_W'(ring_fill);
            expected_stats.push_back(fs);
         end
         default: begin
         end
      endcase
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_window_stats(shown_cmd);
            cmds_accepted++;
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               shown_cmd = pending_cmds.pop_front();
               req_valid     <= 1'b1;
               req_opcode    <= shown_cmd.opcode;
               req_timestamp <= shown_cmd.stamp;
               send_wait = pick_gap(send_idle);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      frame_stats_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_stats.size() == 0) begin
               report_mismatch($sformatf("unexpected result, frame_ticks %0d",
                                         rsp_frame_ticks));
            end else begin
               want = expected_stats.pop_front();
               check_field("frame_ticks", 64'(rsp_frame_ticks), 64'(want.frame_ticks));
               check_field("average_ticks", 64'(rsp_average_ticks),
                           64'(want.average_ticks));
               check_field("minimum_ticks", 64'(rsp_minimum_ticks),
                           64'(want.minimum_ticks));
               check_field("maximum_ticks", 64'(rsp_maximum_ticks),
                           64'(want.maximum_ticks));
               check_field("frames_ended", 64'(rsp_frames_ended), 64'(want.frames_ended));
               check_field("window_filled", 64'(rsp_window_filled),
                           64'(want.window_filled));
               results_checked++;
            end
            recv_wait = pick_gap(recv_idle);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic push_cmd(logic [1:0] opcode, logic [STAMP_W-1:0] stamp);
      command_type cmd;
      cmd.opcode = opcode;
      cmd.stamp  = stamp;
      pending_cmds.push_back(cmd);
      cmds_queued++;
   endtask

   task automatic push_frame(logic [STAMP_W-1:0] start, logic [STAMP_W-1:0] delta);
      push_cmd(OP_FRAME_START, start);
      push_cmd(OP_FRAME_END, start + delta);
   endtask

   // apb write: setup cycle, access cycle, predictor follows at the write edge
   task automatic write_register(logic idx, logic [CSR_DW-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_AW'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (idx == REG_MONITOR_ENABLE) begin
         mon_enabled = data[0];
      end else begin
         win_setting = data[WIN_W-1:0];
         ring_slot   = 0;
         ring_fill   = 0;
      end
      register_writes++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // hold the sender until every result is back, then let the block settle
   task automatic wait_until_drained();
      while (cmds_accepted != cmds_queued || expected_stats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly start/end pairs with random spans, plus loose commands as noise
   task automatic add_random_traffic(int count, int clear_pct);
      int                 pick;
      int                 dsel;
      logic [STAMP_W-1:0] delta;
      logic [STAMP_W-1:0] noise;
      int                 n;
      n = 0;
      while (n < count) begin
         pick  = $urandom_range(0, 99);
         noise = {$urandom, $urandom};
         if (pick < clear_pct) begin
            push_cmd(OP_CLEAR, noise);
            n++;
         end else if (pick < 82) begin
            dsel = $urandom_range(0, 99);
            if (dsel < 70)      delta = 64'($urandom_range(0, 5000));
            else if (dsel < 80) delta = {32'd0, $urandom};
            else if (dsel < 86) delta = 64'hFFFF_FFFF + 64'($urandom_range(0, 2)) - 1;
            else if (dsel < 92) delta = noise;
            else                delta = 64'd0 - 64'($urandom_range(1, 100000));
            push_frame(stamp_now, delta);
            stamp_now += 64'($urandom_range(0, 5000)) + 64'($urandom_range(0, 300));
            n += 2;
         end else if (pick < 89) begin
            // end with whatever start is held
            push_cmd(OP_FRAME_END, stamp_now + 64'($urandom_range(0, 4000)));
            n++;
         end else if (pick < 93) begin
            push_cmd(OP_FRAME_START, noise);
            n++;
         end else if (pick < 97) begin
            push_cmd(OP_UNUSED, noise);
            n++;
         end else begin
            stamp_now = noise;
         end
      end
   endtask

   // stimulus sequence
   initial begin
      logic [CSR_DW-1:0] junk;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: corner spans and special commands at default settings
      send_idle = 1'b0;
      recv_idle = 1'b0;
      push_cmd(OP_FRAME_END, 64'd1000);                     // end with no start
      push_frame(64'd0, 64'd0);                             // zero span
      push_frame(64'd5, 64'hFFFF_FFFF);                     // largest unsaturated
      push_frame(64'd10, 64'h1_0000_0000);                  // just saturates
      push_frame(64'd100, 64'd0 - 64'd50);                  // end before start
      push_cmd(OP_FRAME_START, '1);
      push_cmd(OP_FRAME_END, 64'd5);                        // wraps through zero
      push_cmd(OP_UNUSED, '1);
      push_cmd(OP_UNUSED, '0);
      push_cmd(OP_CLEAR, '0);
      push_cmd(OP_FRAME_END, '1);                           // clear kept the stamp
      push_cmd(OP_FRAME_START, 64'h5555_5555_5555_5555);
      push_cmd(OP_FRAME_END, 64'hAAAA_AAAA_AAAA_AAAA);
      push_cmd(OP_CLEAR, '1);
      push_frame(64'h8000_0000_0000_0000, 64'd7);
      wait_until_drained();

      // full window, long enough to wrap the ring
      send_idle = 1'b1;
      recv_idle = 1'b1;
      add_random_traffic(200, 0);
      wait_until_drained();

      // single-entry window
      junk = $urandom;
      write_register(REG_WINDOW_SIZE, {junk[31:7], 7'd1});
      send_idle = 1'b0;
      add_random_traffic(80, 2);
      wait_until_drained();

      // zero behaves as one
      write_register(REG_WINDOW_SIZE, 32'd0);
      send_idle = 1'b1;
      recv_idle = 1'b0;
      add_random_traffic(60, 2);
      wait_until_drained();

      write_register(REG_WINDOW_SIZE, 32'd2);
      recv_idle = 1'b1;
      add_random_traffic(80, 2);
      wait_until_drained();

      // above depth behaves as full depth
      write_register(REG_WINDOW_SIZE, 32'd127);
      add_random_traffic(120, 0);
      wait_until_drained();

      // monitor off: everything dropped, state kept
      junk = $urandom;
      write_register(REG_MONITOR_ENABLE, {junk[31:1], 1'b0});
      push_cmd(OP_CLEAR, '0);
      push_cmd(OP_FRAME_START, '0);
      add_random_traffic(20, 10);
      wait_until_drained();
      junk = $urandom;
      write_register(REG_MONITOR_ENABLE, {junk[31:1], 1'b1});
      push_cmd(OP_FRAME_END, stamp_now);
      wait_until_drained();

      junk = $urandom;
      write_register(REG_WINDOW_SIZE, {junk[31:7], 7'd64});
      add_random_traffic(150, 1);
      wait_until_drained();

      // a few random window sizes
      for (int k = 0; k < 3; k++) begin
         write_register(REG_WINDOW_SIZE, 32'($urandom_range(3, 63)));
         send_idle = (k != 1);
         recv_idle = (k != 2);
         add_random_traffic(100, 2);
         wait_until_drained();
      end

      $display("%0d commands sent, %0d frame results checked, %0d with saturated span",
               cmds_accepted, results_checked, saturated_ends);
      $display("%0d register writes: window sizes 0 to 127, monitor switched off and on",
               register_writes);
      if (error_count == 0 && expected_stats.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
